@@ rtl/tdkq_pkg.sv @@
// ----------------------------------------------------------------------------
// tdkq_pkg
// Shared types and constants of the tap-dance key qualifier.
// ----------------------------------------------------------------------------
package tdkq_pkg;

    localparam logic [2:0]  NUM_DANCES = 3'd5;
    localparam logic [2:0]  NO_DANCE   = 3'd7;
    localparam logic [15:0] TERM_RESET = 16'd200;
    localparam logic [15:0] IDLE_MAX   = 16'hFFFF;
    localparam logic [7:0]  TAP_MAX    = 8'hFF;

    localparam logic [1:0] ACT_SINGLE = 2'd0;
    localparam logic [1:0] ACT_DOUBLE = 2'd1;
    localparam logic [1:0] ACT_HOLD   = 2'd2;

    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic       last;
        logic       press_out;
        logic [1:0] tap_action;
        logic [2:0] dance_id;
    } t_result;

    // results of one input transaction, first goes out first
    typedef struct packed {
        logic [1:0] count;
        t_result    second;
        t_result    first;
    } t_emit;

endpackage

@@ rtl/tdkq_engine.sv @@
// ----------------------------------------------------------------------------
// tdkq_engine
// Dance state and its single-pass update for one key event or tick.
// ----------------------------------------------------------------------------
module tdkq_engine
    import tdkq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic        i_op,
    input  logic [2:0]  i_dance_key,
    input  logic        i_key_pressed,
    input  logic [15:0] i_tapping_term,
    output t_emit       o_emit
);

    logic [2:0]  r_active_dance, n_active_dance;
    logic [7:0]  r_tap_count,    n_tap_count;
    logic        r_hold_active,  n_hold_active;
    logic [15:0] r_idle_ticks,   n_idle_ticks;
    logic [15:0] idle_inc;
    logic [1:0]  tap_act;
    t_emit       emit;

    assign idle_inc = (r_idle_ticks == IDLE_MAX) ? r_idle_ticks : r_idle_ticks + 16'd1;
    assign tap_act  = (r_tap_count == 8'd1) ? ACT_SINGLE : ACT_DOUBLE;

    always_comb begin
        n_active_dance = r_active_dance;
        n_tap_count    = r_tap_count;
        n_hold_active  = r_hold_active;
        n_idle_ticks   = r_idle_ticks;
        emit           = '0;
        if (i_op == OP_KEY) begin
            // unknown keys leave everything untouched
            if (i_dance_key < NUM_DANCES) begin
                n_idle_ticks = '0;
                if (r_hold_active) begin
                    emit.count        = 2'd1;
                    emit.first        = '{last: 1'b1, press_out: 1'b0,
                                          tap_action: ACT_HOLD,
                                          dance_id: r_active_dance};
                    n_active_dance    = NO_DANCE;
                    n_tap_count       = '0;
                    n_hold_active     = 1'b0;
                end else if (i_key_pressed) begin
                    n_active_dance = i_dance_key;
                end else if (r_active_dance == i_dance_key && r_tap_count != TAP_MAX) begin
                    n_tap_count = r_tap_count + 8'd1;
                end
            end
        end else begin
            n_idle_ticks = idle_inc;
            if (r_active_dance != NO_DANCE && idle_inc > i_tapping_term) begin
                if (r_tap_count == 8'd0) begin
                    if (!r_hold_active) begin
                        emit.count    = 2'd1;
                        emit.first    = '{last: 1'b1, press_out: 1'b1,
                                          tap_action: ACT_HOLD,
                                          dance_id: r_active_dance};
                        n_hold_active = 1'b1;
                    end
                end else begin
                    if (r_tap_count <= 8'd2) begin
                        emit.count  = 2'd2;
                        emit.first  = '{last: 1'b0, press_out: 1'b1,
                                        tap_action: tap_act, dance_id: r_active_dance};
                        emit.second = '{last: 1'b1, press_out: 1'b0,
                                        tap_action: tap_act, dance_id: r_active_dance};
                    end
                    n_active_dance = NO_DANCE;
                    n_tap_count    = '0;
                    n_hold_active  = 1'b0;
                end
            end
        end
    end

    assign o_emit = emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_dance <= NO_DANCE;
            r_tap_count    <= '0;
            r_hold_active  <= 1'b0;
            r_idle_ticks   <= '0;
        end else if (i_accept) begin
            r_active_dance <= n_active_dance;
            r_tap_count    <= n_tap_count;
            r_hold_active  <= n_hold_active;
            r_idle_ticks   <= n_idle_ticks;
        end
    end

endmodule

@@ rtl/tdkq_out_fifo.sv @@
// ----------------------------------------------------------------------------
// tdkq_out_fifo
// Result queue: takes up to two results a cycle, hands out one a cycle while the reader is ready.
// ----------------------------------------------------------------------------
module tdkq_out_fifo
    import tdkq_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_emit   i_emit,
    output logic    o_room,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_result            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count,  n_count;
    logic [PTR_W-1:0]   wr_ptr_1;
    logic [1:0]         push_n;
    logic               pop;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH - 1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    assign push_n   = i_push ? i_emit.count : 2'd0;
    assign pop      = o_valid && i_ready;
    assign wr_ptr_1 = ptr_next(r_wr_ptr);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        if (push_n == 2'd1) begin
            n_wr_ptr = wr_ptr_1;
        end else if (push_n == 2'd2) begin
            n_wr_ptr = ptr_next(wr_ptr_1);
        end
        n_rd_ptr = pop ? ptr_next(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count + CNT_W'(push_n) - CNT_W'(pop);
    end

    assign o_valid = (r_count != '0);
    assign o_room  = (r_count <= CNT_W'(DEPTH - 2));
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_mem[r_wr_ptr] <= i_emit.first;
        end
        if (push_n == 2'd2) begin
            r_mem[wr_ptr_1] <= i_emit.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

@@ rtl/tap_dance_key_qualifier_core.sv @@
// ----------------------------------------------------------------------------
// tap_dance_key_qualifier_core
// Resolves tap-dance key events and ticks into single tap, double tap and
// hold actions.
// ----------------------------------------------------------------------------
// Input stream: one transaction is a key event (tuser 0: key in tdata[2:0],
// pressed flag in tdata[3]) or a time tick (tuser 1). The dance state is
// updated in the cycle the transaction is accepted; its results enter an
// output queue of OUT_DEPTH entries and leave on the output stream in order,
// one result per cycle while the receiver is ready, tlast on the final one
// of a transaction. Throughput: one input transaction per cycle while the
// queue has room for two results; a dance that resolves to a single or
// double tap yields two results, so the sustained rate is set by the output
// drain. s_axis_tready drops when fewer than two queue entries are free,
// which is how a stalled receiver holds off the input side.
// The configuration channel writes the tapping term in any cycle; it is
// always ready. Reset (synchronous, active low) empties the queue, clears
// the dance and the idle counter and sets the tapping term to 200.
// ----------------------------------------------------------------------------
module tap_dance_key_qualifier_core
    import tdkq_pkg::*;
#(
    parameter int OUT_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [2:0] dance_key, [3] key_pressed
    input  logic [0:0]  s_axis_tuser,   // [0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [2:0] dance_id, [4:3] tap_action, [5] press_out
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    logic [15:0] r_tapping_term;
    logic        accept;
    t_emit       emit;
    t_result     head;

    assign accept      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tapping_term <= TERM_RESET;
        end else if (i_cfg_valid) begin
            r_tapping_term <= i_cfg_data;
        end
    end

    tdkq_engine u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_op           (s_axis_tuser[0]),
        .i_dance_key    (s_axis_tdata[2:0]),
        .i_key_pressed  (s_axis_tdata[3]),
        .i_tapping_term (r_tapping_term),
        .o_emit         (emit)
    );

    tdkq_out_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_emit  (emit),
        .o_room  (s_axis_tready),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (head)
    );

    assign m_axis_tdata = {2'b00, head.press_out, head.tap_action, head.dance_id};
    assign m_axis_tlast = head.last;

endmodule

@@ rtl/tdkq_checker.sv @@
// ----------------------------------------------------------------------------
// tdkq_checker
// Port-level checks of the tap-dance key qualifier, bound to the top level.
// ----------------------------------------------------------------------------
module tdkq_checker
    import tdkq_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);

    // queue is empty right after reset: input open, output idle
    a_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("input not ready after reset");

    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output transaction changed while stalled");

    a_action_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[4:3] != 2'd3)
        else $error("undefined tap action");

    // a tap press is always followed by its release from the same transaction
    a_tap_press_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[5] && m_axis_tdata[4:3] != ACT_HOLD
            |-> !m_axis_tlast)
        else $error("tap press marked last");

endmodule

bind tap_dance_key_qualifier_core tdkq_checker u_tdkq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
